### hdl/rmq_pkg.sv
// rmq_pkg: shared types and codes for the rotation matrix to quaternion block
// no dependencies

package rmq_pkg;

	// codes of the winning quaternion part
	localparam logic [1:0] PART_W = 2'd0;
	localparam logic [1:0] PART_X = 2'd1;
	localparam logic [1:0] PART_Y = 2'd2;
	localparam logic [1:0] PART_Z = 2'd3;

	// control that travels with each beat through the cell chains
	typedef struct packed {
		logic       vld;
		logic [1:0] part;
	} rmq_ctl_t;

endpackage

### hdl/rmq_sqrt_cell.sv
// rmq_sqrt_cell: one stage of the square-root chain, one root bit per cell
// depends on rmq_pkg

module rmq_sqrt_cell import rmq_pkg::*; #(
	parameter int W  = 16,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  rmq_ctl_t        ctl_i,
	input  logic [2*W-1:0]  n_i,
	input  logic [W+2:0]    rem_i,
	input  logic [W-1:0]    root_i,
	input  logic [SW-1:0]   side_i,
	output rmq_ctl_t        ctl_o,
	output logic [2*W-1:0]  n_o,
	output logic [W+2:0]    rem_o,
	output logic [W-1:0]    root_o,
	output logic [SW-1:0]   side_o
);

	logic [W+2:0] rem2;
	logic [W+2:0] trial;
	logic         ge;
	logic [W+2:0] nrem;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		rem2  = {rem_i[W:0], n_i[2*W-1:2*W-2]};
		trial = {1'b0, root_i, 2'b01};
		ge    = rem2 >= trial;
		nrem  = ge ? rem2 - trial : rem2;
	end

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (adv) begin
			ctl_o <= ctl_i;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			n_o    <= {n_i[2*W-3:0], 2'b00};
			rem_o  <= nrem;
			root_o <= {root_i[W-2:0], ge};
			side_o <= side_i;
		end
	end

endmodule

### hdl/rmq_div_cell.sv
// rmq_div_cell: one stage of the three-lane restoring divider, one quotient bit per cell
// depends on rmq_pkg

module rmq_div_cell import rmq_pkg::*; #(
	parameter int W  = 16,
	parameter int SW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  rmq_ctl_t           ctl_i,
	input  logic [W:0]         dvs_i,
	input  logic [2:0][W:0]    rem_i,
	input  logic [2:0][W:0]    low_i,
	input  logic [2:0][W:0]    q_i,
	input  logic [SW-1:0]      side_i,
	output rmq_ctl_t           ctl_o,
	output logic [W:0]         dvs_o,
	output logic [2:0][W:0]    rem_o,
	output logic [2:0][W:0]    low_o,
	output logic [2:0][W:0]    q_o,
	output logic [SW-1:0]      side_o
);

	logic [2:0][W+1:0] rem2;
	logic [2:0]        ge;
	logic [2:0][W+1:0] nrem;

	// shift in one dividend bit per lane and compare against the divisor
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rem2[j] = {rem_i[j], low_i[j][W]};
			ge[j]   = rem2[j] >= {1'b0, dvs_i};
			nrem[j] = ge[j] ? rem2[j] - {1'b0, dvs_i} : rem2[j];
		end
	end

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (adv) begin
			ctl_o <= ctl_i;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			dvs_o  <= dvs_i;
			side_o <= side_i;
			for (int j = 0; j < 3; j++) begin
				rem_o[j] <= nrem[j][W:0];
				low_o[j] <= {low_i[j][W-1:0], 1'b0};
				q_o[j]   <= {q_i[j][W-1:0], ge[j]};
			end
		end
	end

endmodule

### hdl/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level, candidate pick, sqrt and divider chains
// depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell

// Converts a 3x3 rotation matrix in signed Q2.(DATA_WIDTH-2) into a unit quaternion
// by Shepperd's method. One beat is accepted every cycle while the output is not
// stalled. A beat passes an input register, then two chains of cells: DATA_WIDTH
// square-root cells, one root bit each, and after a register DATA_WIDTH+1 divider
// cells, one quotient bit each for three lanes at once, then an output register. A stall
// on the output freezes the whole pipeline and is passed back as the input stall.
// When the halved square root is zero the four parts read zero and degenerate is set.

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] r11,
	input  logic signed [DATA_WIDTH-1:0] r12,
	input  logic signed [DATA_WIDTH-1:0] r13,
	input  logic signed [DATA_WIDTH-1:0] r21,
	input  logic signed [DATA_WIDTH-1:0] r22,
	input  logic signed [DATA_WIDTH-1:0] r23,
	input  logic signed [DATA_WIDTH-1:0] r31,
	input  logic signed [DATA_WIDTH-1:0] r32,
	input  logic signed [DATA_WIDTH-1:0] r33,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] qw,
	output logic signed [DATA_WIDTH-1:0] qx,
	output logic signed [DATA_WIDTH-1:0] qy,
	output logic signed [DATA_WIDTH-1:0] qz,
	output logic [1:0]                   largest_part,
	output logic                         degenerate
);

	localparam int DW   = DATA_WIDTH;
	localparam int FRAC = DW - 2;
	localparam int CW   = DW + 2;
	localparam int SQS  = 3 * (DW + 1);
	localparam int DVS  = DW + 6;
	localparam int NDIV = DW + 1;

	logic adv;

	// whole pipeline moves unless a finished beat is held at the output
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// candidate sums, pick of the winner, radicand and pair values
	logic signed [CW-1:0]  e11, e12, e13, e21, e22, e23, e31, e32, e33;
	logic signed [CW-1:0]  tw, tx, ty, tz, best, sval;
	logic [1:0]            part;
	logic signed [DW:0]    dA, dB, dC, sP, sQ, sR;
	logic [2:0][DW:0]      dsel;
	logic [DW:0]           sclamp;

	always_comb begin
		e11 = CW'(r11); e12 = CW'(r12); e13 = CW'(r13);
		e21 = CW'(r21); e22 = CW'(r22); e23 = CW'(r23);
		e31 = CW'(r31); e32 = CW'(r32); e33 = CW'(r33);
		tw = e11 + e22 + e33;
		tx = e11 - e22 - e33;
		ty = e22 - e11 - e33;
		tz = e33 - e11 - e22;
		best = tw;
		part = PART_W;
		if (tx > best) begin
			best = tx;
			part = PART_X;
		end
		if (ty > best) begin
			best = ty;
			part = PART_Y;
		end
		if (tz > best) begin
			best = tz;
			part = PART_Z;
		end
		sval   = best + (CW'(1) <<< FRAC);
		sclamp = sval[CW-1] ? '0 : sval[DW:0];
		dA = (DW+1)'(e23 - e32);
		dB = (DW+1)'(e31 - e13);
		dC = (DW+1)'(e12 - e21);
		sP = (DW+1)'(e12 + e21);
		sQ = (DW+1)'(e31 + e13);
		sR = (DW+1)'(e23 + e32);
		unique case (part)
			PART_W: dsel = {dC, dB, dA};
			PART_X: dsel = {sQ, sP, dA};
			PART_Y: dsel = {sR, sP, dB};
			PART_Z: dsel = {sR, sQ, dC};
			default: dsel = {dC, dB, dA};
		endcase
	end

	rmq_ctl_t          ctl_s1;
	logic [2*DW-1:0]   n_s1;
	logic [2:0][DW:0]  d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{vld: in_valid, part: part};
		end
	end

	// radicand is the clamped sum scaled up by the fraction bits
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= {1'b0, sclamp, {FRAC{1'b0}}};
			d_s1 <= dsel;
		end
	end

	// square-root chain
	rmq_ctl_t          sq_ctl  [0:DW];
	logic [2*DW-1:0]   sq_n    [0:DW];
	logic [DW+2:0]     sq_rem  [0:DW];
	logic [DW-1:0]     sq_root [0:DW];
	logic [SQS-1:0]    sq_side [0:DW];

	assign sq_ctl[0]  = ctl_s1;
	assign sq_n[0]    = n_s1;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = d_s1;

	for (genvar k = 0; k < DW; k++) begin : g_sqrt
		rmq_sqrt_cell #(.W(DW), .SW(SQS)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.ctl_i (sq_ctl[k]),
			.n_i   (sq_n[k]),
			.rem_i (sq_rem[k]),
			.root_i(sq_root[k]),
			.side_i(sq_side[k]),
			.ctl_o (sq_ctl[k+1]),
			.n_o   (sq_n[k+1]),
			.rem_o (sq_rem[k+1]),
			.root_o(sq_root[k+1]),
			.side_o(sq_side[k+1])
		);
	end

	// divisor, sign-magnitude split and overflow check ahead of the divider
	logic [2:0][DW:0]     dq;
	logic [DW-2:0]        bval;
	logic [DW:0]          dvs;
	logic [2:0]           neg, ovf;
	logic [2:0][DW:0]     mag;
	logic [2:0][2*DW-2:0] dvd;
	logic [2:0][DW:0]     rem0, low0;

	always_comb begin
		dq   = sq_side[DW];
		bval = sq_root[DW][DW-1:1];
		dvs  = {sq_root[DW][DW-1:1], 2'b00};
		for (int j = 0; j < 3; j++) begin
			neg[j]  = dq[j][DW];
			mag[j]  = neg[j] ? (DW+1)'(-dq[j]) : dq[j];
			dvd[j]  = {mag[j], {FRAC{1'b0}}};
			rem0[j] = (DW+1)'(dvd[j][2*DW-2:DW+1]);
			low0[j] = dvd[j][DW:0];
			ovf[j]  = rem0[j] >= dvs;
		end
	end

	rmq_ctl_t          ctl_s2;
	logic [DW:0]       dvs_s2;
	logic [2:0][DW:0]  rem_s2, low_s2;
	logic [DVS-1:0]    side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= sq_ctl[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvs_s2  <= dvs;
			rem_s2  <= rem0;
			low_s2  <= low0;
			side_s2 <= {bval, bval == '0, neg, ovf};
		end
	end

	// divider chain
	rmq_ctl_t          dv_ctl  [0:NDIV];
	logic [DW:0]       dv_dvs  [0:NDIV];
	logic [2:0][DW:0]  dv_rem  [0:NDIV];
	logic [2:0][DW:0]  dv_low  [0:NDIV];
	logic [2:0][DW:0]  dv_q    [0:NDIV];
	logic [DVS-1:0]    dv_side [0:NDIV];

	assign dv_ctl[0]  = ctl_s2;
	assign dv_dvs[0]  = dvs_s2;
	assign dv_rem[0]  = rem_s2;
	assign dv_low[0]  = low_s2;
	assign dv_q[0]    = '0;
	assign dv_side[0] = side_s2;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		rmq_div_cell #(.W(DW), .SW(DVS)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.ctl_i (dv_ctl[k]),
			.dvs_i (dv_dvs[k]),
			.rem_i (dv_rem[k]),
			.low_i (dv_low[k]),
			.q_i   (dv_q[k]),
			.side_i(dv_side[k]),
			.ctl_o (dv_ctl[k+1]),
			.dvs_o (dv_dvs[k+1]),
			.rem_o (dv_rem[k+1]),
			.low_o (dv_low[k+1]),
			.q_o   (dv_q[k+1]),
			.side_o(dv_side[k+1])
		);
	end

	// saturation, sign and placement of the lanes around the winning part
	localparam logic [DW:0] LIM = (DW+1)'(1) << (DW - 1);

	logic [DW-2:0]         fb;
	logic                  fdeg;
	logic [2:0]            fneg, fovf;
	logic [2:0][DW:0]      fq;
	logic [2:0][DW-1:0]    lane;
	logic [3:0][DW-1:0]    slot;
	logic [1:0]            fpart;

	always_comb begin
		{fb, fdeg, fneg, fovf} = dv_side[NDIV];
		fpart = dv_ctl[NDIV].part;
		for (int j = 0; j < 3; j++) begin
			fq[j] = dv_q[NDIV][j];
			if (fneg[j]) begin
				if (fovf[j] || fq[j] > LIM) begin
					fq[j] = LIM;
				end
				lane[j] = DW'(-fq[j]);
			end else begin
				if (fovf[j] || fq[j] > LIM - 1'b1) begin
					fq[j] = LIM - 1'b1;
				end
				lane[j] = fq[j][DW-1:0];
			end
		end
		unique case (fpart)
			PART_W: slot = {lane[2], lane[1], lane[0], {1'b0, fb}};
			PART_X: slot = {lane[2], lane[1], {1'b0, fb}, lane[0]};
			PART_Y: slot = {lane[2], {1'b0, fb}, lane[1], lane[0]};
			PART_Z: slot = {{1'b0, fb}, lane[2], lane[1], lane[0]};
			default: slot = {lane[2], lane[1], lane[0], {1'b0, fb}};
		endcase
		if (fdeg) begin
			slot = '0;
		end
	end

	// output register
	logic                  out_valid_q;
	logic [3:0][DW-1:0]    slot_q;
	logic [1:0]            part_q;
	logic                  deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_ctl[NDIV].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_q <= slot;
			part_q <= fpart;
			deg_q  <= fdeg;
		end
	end

	assign out_valid    = out_valid_q;
	assign qw           = slot_q[0];
	assign qx           = slot_q[1];
	assign qy           = slot_q[2];
	assign qz           = slot_q[3];
	assign largest_part = part_q;
	assign degenerate   = deg_q;

	// degenerate beats carry an all-zero quaternion
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> qw == '0 && qx == '0 && qy == '0 && qz == '0)
		else $error("degenerate beat with nonzero parts");

	// the winning part of a regular beat is positive
	a_win_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |->
			(largest_part == PART_W && !qw[DW-1] && qw != '0) ||
			(largest_part == PART_X && !qx[DW-1] && qx != '0) ||
			(largest_part == PART_Y && !qy[DW-1] && qy != '0) ||
			(largest_part == PART_Z && !qz[DW-1] && qz != '0))
		else $error("winning part not positive");

	// a held result freezes the whole pipeline
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dv_ctl[NDIV]) && $stable(ctl_s1))
		else $error("pipeline moved while output held");

endmodule

### sim/tb.sv
// tb: self-checking bench for rotation_matrix_to_quaternion (matrix to quaternion)
// depends on rmq_pkg and the rotation_matrix_to_quaternion RTL; holds its own predictor

`timescale 1ns / 100ps

module tb;
	import rmq_pkg::*;

	localparam int DW = 16;
	localparam int FR = DW - 2;
	localparam int LATENCY = 2 * DW + 4;

	typedef logic signed [DW-1:0] word_t;

	typedef struct {
		word_t      w, x, y, z;
		logic [1:0] part;
		logic       degen;
	} quat_t;

	// integer square root, truncated
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, bt;
		r = 0;
		bt = 64'h1 << 62;
		while (bt > n) bt >>= 2;
		while (bt != 0) begin
			if (n >= r + bt) begin
				n -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		return r;
	endfunction

	// pair value over 4*b, truncated toward zero, saturated
	function automatic word_t scaled_pair(longint d, longint unsigned b);
		longint unsigned mag, q, lim;
		mag = (d < 0) ? -d : d;
		q = (mag << FR) / (b * 4);
		lim = 64'h1 << (DW - 1);
		if (d < 0) begin
			if (q > lim) q = lim;
			return word_t'(-q);
		end
		if (q > lim - 1) q = lim - 1;
		return word_t'(q);
	endfunction

	function automatic quat_t convert_matrix(word_t m[9]);
		longint c[4], best, s, dA, dB, dC, sP, sQ, sR;
		longint unsigned b;
		int idx;
		quat_t r;
		word_t bw;
		c[0] = longint'(m[0]) + m[4] + m[8];
		c[1] = longint'(m[0]) - m[4] - m[8];
		c[2] = longint'(m[4]) - m[0] - m[8];
		c[3] = longint'(m[8]) - m[0] - m[4];
		dA = longint'(m[5]) - m[7]; dB = longint'(m[6]) - m[2]; dC = longint'(m[1]) - m[3];
		sP = longint'(m[1]) + m[3]; sQ = longint'(m[6]) + m[2]; sR = longint'(m[5]) + m[7];
		best = c[0];
		idx = 0;
		for (int k = 1; k < 4; k++)
			if (c[k] > best) begin
				best = c[k];
				idx = k;
			end
		s = best + (64'sd1 <<< FR);
		if (s < 0) s = 0;
		b = root_floor(longint'(s) << FR) >> 1;
		r.part = idx[1:0];
		r.degen = (b == 0);
		r.w = 0; r.x = 0; r.y = 0; r.z = 0;
		if (b == 0) return r;
		bw = (b > (64'h1 << (DW - 1)) - 1) ? word_t'((64'h1 << (DW - 1)) - 1) : word_t'(b);
		case (r.part)
			PART_W: begin
				r.w = bw; r.x = scaled_pair(dA, b);
				r.y = scaled_pair(dB, b); r.z = scaled_pair(dC, b);
			end
			PART_X: begin
				r.x = bw; r.w = scaled_pair(dA, b);
				r.y = scaled_pair(sP, b); r.z = scaled_pair(sQ, b);
			end
			PART_Y: begin
				r.y = bw; r.w = scaled_pair(dB, b);
				r.x = scaled_pair(sP, b); r.z = scaled_pair(sR, b);
			end
			default: begin
				r.z = bw; r.w = scaled_pair(dC, b);
				r.x = scaled_pair(sQ, b); r.y = scaled_pair(sR, b);
			end
		endcase
		return r;
	endfunction

	// expected quaternions in order of acceptance
	class quat_scoreboard;
		quat_t pending[$];
		int errors;
		int checked;
		int degen_seen;

		function void note_matrix(word_t m[9]);
			pending.push_back(convert_matrix(m));
		endfunction

		function void check_quat(quat_t got);
			quat_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat");
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.degen) degen_seen++;
			if (got.w !== e.w) begin $error("qw exp %0d got %0d", e.w, got.w); errors++; end
			if (got.x !== e.x) begin $error("qx exp %0d got %0d", e.x, got.x); errors++; end
			if (got.y !== e.y) begin $error("qy exp %0d got %0d", e.y, got.y); errors++; end
			if (got.z !== e.z) begin $error("qz exp %0d got %0d", e.z, got.z); errors++; end
			if (got.part !== e.part) begin
				$error("largest_part exp %0d got %0d", e.part, got.part); errors++;
			end
			if (got.degen !== e.degen) begin
				$error("degenerate exp %0d got %0d", e.degen, got.degen); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall;
	word_t r11, r12, r13, r21, r22, r23, r31, r32, r33, qw, qx, qy, qz;
	logic [1:0] largest_part;
	logic degenerate;

	quat_scoreboard sb;
	int sent;
	bit idle_en;
	bit hold_on;
	bit stim_done;

	rotation_matrix_to_quaternion #(.DATA_WIDTH(DW)) u_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end

	// drive one matrix beat and wait for acceptance
	task automatic send_matrix(word_t m[9]);
		while (idle_en && $urandom_range(99) < 28) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		{r11, r12, r13, r21, r22, r23, r31, r32, r33} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		do @(posedge clk); while (in_stall);
		sb.note_matrix(m);
		sent++;
	endtask

	function automatic word_t rand_word();
		return word_t'($urandom);
	endfunction

	// near-rotation matrix: a signed permutation with small jitter
	function automatic void near_rotation(ref word_t m[9]);
		int p[3];
		int j;
		p = '{0, 1, 2};
		p.shuffle();
		for (int i = 0; i < 9; i++) m[i] = word_t'($signed($urandom_range(800)) - 400);
		for (int i = 0; i < 3; i++) begin
			j = i * 3 + p[i];
			m[j] = $urandom_range(1) ? word_t'(16384 - $urandom_range(3000))
				: word_t'(-16384 + $urandom_range(3000));
		end
	endfunction

	initial begin
		word_t m[9];
		sb = new();
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		idle_en = 0;
		hold_on = 0;
		stim_done = 0;
		{r11, r12, r13, r21, r22, r23, r31, r32, r33} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: identity, half turns per axis, extremes, ties
		m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(m);
		m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(m);
		m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(m);
		m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(m);
		m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_matrix(m);
		for (int i = 0; i < 9; i++) m[i] = -32768; send_matrix(m);
		for (int i = 0; i < 9; i++) m[i] = 32767; send_matrix(m);
		m = '{32767, -32768, 32767, -32768, -32768, -32768, 32767, -32768, -32768};
		send_matrix(m);
		m = '{-32768, 32767, -32768, 32767, 32767, 32767, -32768, 32767, -32768};
		send_matrix(m);
		m = '{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192}; send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
		m = '{-5462, 32767, 1, -32768, -5462, 0, 0, 5, -5461}; send_matrix(m);
		m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 0}; send_matrix(m);
		m = '{1, 32767, -32768, 32767, -1, 32767, -32768, -32768, 0}; send_matrix(m);

		// random: mostly near-rotations, some raw bit patterns
		idle_en = 1;
		for (int n = 0; n < 1450; n++) begin
			if (n == 300) idle_en = 0;
			if (n == 600) idle_en = 1;
			if (n == 800) hold_on = 1;
			if ($urandom_range(99) < 75) near_rotation(m);
			else for (int i = 0; i < 9; i++) m[i] = rand_word();
			send_matrix(m);
		end
		in_valid <= 0;
		stim_done = 1;
	end

	// receiver side: random stall, idle-free stretch, one long hold-off
	initial begin
		int cnt;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_on) begin
				hold_on = 0;
				out_stall <= 1;
				cnt = 0;
				while (cnt < 200) begin
					@(posedge clk);
					cnt++;
				end
			end
			out_stall <= idle_en && ($urandom_range(99) < 28);
		end
	end

	// sample results at the edge
	always @(posedge clk) begin
		quat_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.w = qw; got.x = qx; got.y = qy; got.z = qz;
			got.part = largest_part;
			got.degen = degenerate;
			sb.check_quat(got);
		end
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d matrices, %0d results checked, %0d degenerate",
			sent, sb.checked, sb.degen_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
